@@ design/pfdm_pkg.sv @@
// ----------------------------------------------------------------------------
// pfdm_pkg
// Shared types and constants of the PCM frame downmix block.
// ----------------------------------------------------------------------------
package pfdm_pkg;

   localparam int BYTE_W          = 8;
   localparam int SAMPLE_W        = 16;
   localparam int CHANNEL_COUNT_W = 4;
   localparam int FRAME_BYTES_W   = 7;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNEL_COUNT = 2'd0,
      CSR_WIDE_SAMPLES  = 2'd1,
      CSR_FRAME_BYTES   = 2'd2
   } csr_index_type;

   localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RST = 4'd1;
   localparam logic                       WIDE_SAMPLES_RST  = 1'b1;
   localparam logic [FRAME_BYTES_W-1:0]   FRAME_BYTES_RST   = 7'd2;

   localparam int SAMPLE_MIN = -32768;
   localparam int SAMPLE_MAX = 32767;

endpackage

@@ design/pfdm_front.sv @@
// ----------------------------------------------------------------------------
// pfdm_front
// Byte intake: config registers, frame position, channel sum accumulation.
// Pushes one divide job per finished frame.
// ----------------------------------------------------------------------------
module pfdm_front import pfdm_pkg::*; #(
   parameter int MAX_CHANNELS    = 8,
   parameter int MAX_FRAME_BYTES = 64,
   parameter int SUM_W           = 20,
   parameter int CH_W            = 4,
   parameter int POS_W           = 6,
   parameter int ENTRY_W         = SUM_W + CH_W + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  logic                  q_full,
   output logic                  q_push,
   output logic [ENTRY_W-1:0]    q_data
);

   localparam int CMP_W = (POS_W + 2 > FRAME_BYTES_W + 2) ? POS_W + 2 : FRAME_BYTES_W + 2;

   logic [CHANNEL_COUNT_W-1:0] channel_count_ff;
   logic                       wide_samples_ff;
   logic [FRAME_BYTES_W-1:0]   frame_bytes_ff;

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_add;
   logic [BYTE_W-1:0]       hold_ff, hold_in;

   logic [CMP_W-1:0]        cc_c, ch_c, fb_c, flen_c, pos_c, pos_next_c;
   logic                    frame_end, accept;
   logic signed [SAMPLE_W-1:0] wide_sample;

   always_comb begin
      cc_c = CMP_W'(channel_count_ff);
      if (cc_c == '0) begin
         ch_c = CMP_W'(1);
      end else if (cc_c > CMP_W'(MAX_CHANNELS)) begin
         ch_c = CMP_W'(MAX_CHANNELS);
      end else begin
         ch_c = cc_c;
      end
      fb_c = CMP_W'(frame_bytes_ff);
      if (fb_c == '0) begin
         flen_c = CMP_W'(1);
      end else if (fb_c > CMP_W'(MAX_FRAME_BYTES)) begin
         flen_c = CMP_W'(MAX_FRAME_BYTES);
      end else begin
         flen_c = fb_c;
      end
      pos_c      = CMP_W'(pos_ff);
      pos_next_c = pos_c + CMP_W'(1);
      frame_end  = (pos_next_c >= flen_c);
   end

   assign req_full = q_full && frame_end;
   assign accept   = req_push && !req_full;
   assign wide_sample = {req_data_byte, hold_ff};

   always_comb begin
      hold_in = hold_ff;
      sum_add = sum_ff;
      if (wide_samples_ff) begin
         if (pos_c < (ch_c << 1)) begin
            if (!pos_ff[0]) begin
               hold_in = req_data_byte;
            end else begin
               sum_add = sum_ff + SUM_W'(wide_sample);
            end
         end
      end else if (pos_c < ch_c) begin
         sum_add = sum_ff + $signed({{(SUM_W-BYTE_W){1'b0}}, req_data_byte});
      end
      if (frame_end) begin
         pos_in  = '0;
         sum_in  = '0;
         hold_in = '0;
      end else begin
         pos_in  = pos_next_c[POS_W-1:0];
         sum_in  = sum_add;
      end
   end

   assign q_push = accept && frame_end;
   assign q_data = {sum_add, ch_c[CH_W-1:0], wide_samples_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CHANNEL_COUNT_RST;
         wide_samples_ff  <= WIDE_SAMPLES_RST;
         frame_bytes_ff   <= FRAME_BYTES_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[CHANNEL_COUNT_W-1:0];
            CSR_WIDE_SAMPLES:  wide_samples_ff  <= csr_data[0];
            CSR_FRAME_BYTES:   frame_bytes_ff   <= csr_data[FRAME_BYTES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sum_ff  <= '0;
         hold_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         hold_ff <= hold_in;
      end
   end

endmodule

@@ design/pfdm_fifo.sv @@
// ----------------------------------------------------------------------------
// pfdm_fifo
// Short show-ahead queue between the byte intake and the divide stage.
// ----------------------------------------------------------------------------
module pfdm_fifo #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         count_ff <= count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
      end
   end

endmodule

@@ design/pfdm_back.sv @@
// ----------------------------------------------------------------------------
// pfdm_back
// Divide stage: sum / channel count toward zero by reciprocal multiply with
// one correction step, clamp in 16-bit mode, result output register.
// ----------------------------------------------------------------------------
module pfdm_back import pfdm_pkg::*; #(
   parameter int MAX_CHANNELS = 8,
   parameter int SUM_W        = 20,
   parameter int CH_W         = 4,
   parameter int ENTRY_W      = SUM_W + CH_W + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  logic [ENTRY_W-1:0]         q_data,
   output logic                       q_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [SAMPLE_W-1:0] rsp_mono_sample
);

   localparam int MAG_W  = SUM_W;
   localparam int K      = SUM_W;
   localparam int PROD_W = MAG_W + K + 1;
   localparam int QD_W   = MAG_W + CH_W;
   localparam int TAB_N  = 1 << CH_W;

   logic [K:0] recip_tab [TAB_N];

   for (genvar g = 0; g < TAB_N; g++) begin : g_recip
      localparam longint unsigned DIV   = (g == 0 || g > MAX_CHANNELS) ? 1 : g;
      localparam longint unsigned ONE_K = 64'd1 << K;
      localparam longint unsigned RECIP = ONE_K / DIV;
      assign recip_tab[g] = (K+1)'(RECIP);
   end

   logic [SUM_W-1:0] in_sum;
   logic [CH_W-1:0]  in_ch;
   logic             in_wide;
   logic [MAG_W-1:0] in_mag;
   logic             in_neg;

   assign {in_sum, in_ch, in_wide} = q_data;
   assign in_neg = in_sum[SUM_W-1];
   assign in_mag = in_neg ? (~in_sum + MAG_W'(1)) : in_sum;

   logic              s1_valid_ff, s2_valid_ff;
   logic [PROD_W-1:0] s1_prod_ff;
   logic [MAG_W-1:0]  s1_mag_ff;
   logic [CH_W-1:0]   s1_ch_ff;
   logic              s1_neg_ff, s1_wide_ff;
   logic signed [SAMPLE_W-1:0] s2_out_ff, s2_out_in;

   logic ready2, adv1, ready1;

   assign ready2 = !s2_valid_ff || rsp_pop;
   assign adv1   = s1_valid_ff && ready2;
   assign ready1 = !s1_valid_ff || adv1;
   assign q_pop  = q_valid && ready1;

   logic [MAG_W-1:0]       q0, quo;
   logic [QD_W-1:0]        qd, rem;
   logic signed [MAG_W:0]  sres;

   always_comb begin
      q0   = s1_prod_ff[K +: MAG_W];
      qd   = QD_W'(q0) * QD_W'(s1_ch_ff);
      rem  = QD_W'(s1_mag_ff) - qd;
      quo  = q0 + MAG_W'(rem >= QD_W'(s1_ch_ff));
      sres = s1_neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      if (s1_wide_ff && sres < (MAG_W+1)'(SAMPLE_MIN)) begin
         s2_out_in = SAMPLE_W'(SAMPLE_MIN);
      end else if (s1_wide_ff && sres > (MAG_W+1)'(SAMPLE_MAX)) begin
         s2_out_in = SAMPLE_W'(SAMPLE_MAX);
      end else begin
         s2_out_in = sres[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_prod_ff <= PROD_W'(in_mag) * PROD_W'(recip_tab[in_ch]);
         s1_mag_ff  <= in_mag;
         s1_ch_ff   <= in_ch;
         s1_neg_ff  <= in_neg;
         s1_wide_ff <= in_wide;
      end
      if (adv1) begin
         s2_out_ff <= s2_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (ready1) begin
            s1_valid_ff <= q_valid;
         end
         if (ready2) begin
            s2_valid_ff <= adv1;
         end
      end
   end

   assign rsp_empty       = !s2_valid_ff;
   assign rsp_mono_sample = s2_out_ff;

endmodule

@@ design/pcm_frame_downmix.sv @@
// ----------------------------------------------------------------------------
// pcm_frame_downmix
// Mixes an interleaved PCM byte stream (u8 or s16le) down to mono samples.
//
//   channel  | direction | handshake         | beat
//   req_     | in        | req_push/req_full | one data byte
//   rsp_     | out       | rsp_empty/rsp_pop | one mono sample per frame
//   csr_     | in        | csr_write         | one register write
//
// One byte per cycle is taken while req_full is low. A frame's sample
// passes through the job queue and the reciprocal multiply register, then
// correction and clamp feed the result register that drives the rsp_ ports.
// req_full rises only on a frame's last byte while the job queue is full.
// Synchronous active-high reset restores register defaults, empties all.
// ----------------------------------------------------------------------------
module pcm_frame_downmix import pfdm_pkg::*; #(
   parameter int MAX_CHANNELS    = 8,
   parameter int MAX_FRAME_BYTES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [BYTE_W-1:0]          req_data_byte,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [SAMPLE_W-1:0] rsp_mono_sample
);

   localparam int SUM_W   = $clog2(MAX_CHANNELS) + 17;
   localparam int CH_W    = $clog2(MAX_CHANNELS + 1);
   localparam int POS_W   = $clog2(MAX_FRAME_BYTES);
   localparam int ENTRY_W = SUM_W + CH_W + 1;

   logic               q_push, q_full, q_valid, q_pop;
   logic [ENTRY_W-1:0] q_push_data, q_pop_data;

   pfdm_front #(
      .MAX_CHANNELS    (MAX_CHANNELS),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .SUM_W           (SUM_W),
      .CH_W            (CH_W),
      .POS_W           (POS_W),
      .ENTRY_W         (ENTRY_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_push_data)
   );

   pfdm_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .valid     (q_valid),
      .pop_data  (q_pop_data),
      .pop       (q_pop)
   );

   pfdm_back #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SUM_W        (SUM_W),
      .CH_W         (CH_W),
      .ENTRY_W      (ENTRY_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_pop_data),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_mono_sample (rsp_mono_sample)
   );

endmodule

@@ design/pfdm_checker.sv @@
// ----------------------------------------------------------------------------
// pfdm_checker
// Port-level checks of the PCM frame downmix block.
// ----------------------------------------------------------------------------
module pfdm_checker import pfdm_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_full,
   input logic                       rsp_empty,
   input logic                       rsp_pop,
   input logic signed [SAMPLE_W-1:0] rsp_mono_sample
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("not empty after reset");

   a_min_latency: assert property (@(posedge clock)
      reset |=> rsp_empty ##1 rsp_empty ##1 rsp_empty)
      else $error("result earlier than pipeline latency");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_mono_sample))
      else $error("stalled result changed");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input stalled while no result waits");

endmodule

bind pcm_frame_downmix pfdm_checker u_pfdm_checker (.*);
